>>> rtl/ctod_pkg.sv
// shared widths, register codes and beat types for the counter to time-of-day block
// no dependencies; every other file imports this package
package ctod_pkg;

    localparam int COUNT_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int FRAC_W     = 32;
    localparam int SHIFT_W    = 7;
    localparam int WALL_NS_W  = 30;
    localparam int USEC_W     = 20;

    localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;
    localparam logic [63:0] NS_PER_US  = 64'd1_000;

    // register codes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNTER_BASE  = 3'd0,
        CFG_TIME_BASE_NS  = 3'd1,
        CFG_SCALE_FRAC    = 3'd2,
        CFG_SCALE_SHIFT   = 3'd3,
        CFG_WALL_SECONDS  = 3'd4,
        CFG_WALL_NS       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [COUNT_W-1:0]          counter_base;
        logic [COUNT_W-1:0]          time_base_ns;
        logic [FRAC_W-1:0]           scale_fraction;
        logic signed [SHIFT_W-1:0]   scale_shift;
        logic [COUNT_W-1:0]          wall_seconds;
        logic [WALL_NS_W-1:0]        wall_nanoseconds;
    } t_cfg;

    // monotonic time beat passed from the scaling pipe to the split pipe
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] mono;
    } t_mono_beat;

endpackage

>>> rtl/ctod_in_if.sv
// input channel carrying one raw counter reading per beat
// depends on ctod_pkg
interface ctod_in_if import ctod_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] counter_now;

    modport source (output valid, output counter_now, input ready);
    modport sink   (input valid, input counter_now, output ready);
endinterface

>>> rtl/ctod_out_if.sv
// output channel carrying monotonic and wall-clock time per beat
// depends on ctod_pkg
interface ctod_out_if import ctod_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] monotonic_ns;
    logic [COUNT_W-1:0] seconds;
    logic [USEC_W-1:0]  microseconds;

    modport source (output valid, output monotonic_ns, output seconds, output microseconds,
                    input ready);
    modport sink   (input valid, input monotonic_ns, input seconds, input microseconds,
                    output ready);
endinterface

>>> rtl/ctod_cfg_if.sv
// configuration write channel: register index plus write data per beat
// depends on ctod_pkg
interface ctod_cfg_if import ctod_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/ctod_cfg_regs.sv
// configuration register file, written through the configuration channel
// depends on ctod_pkg and ctod_cfg_if
module ctod_cfg_regs import ctod_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctod_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COUNTER_BASE: r_cfg.counter_base     <= i_cfg.data;
                CFG_TIME_BASE_NS: r_cfg.time_base_ns     <= i_cfg.data;
                CFG_SCALE_FRAC:   r_cfg.scale_fraction   <= i_cfg.data[FRAC_W-1:0];
                CFG_SCALE_SHIFT:  r_cfg.scale_shift      <= $signed(i_cfg.data[SHIFT_W-1:0]);
                CFG_WALL_SECONDS: r_cfg.wall_seconds     <= i_cfg.data;
                CFG_WALL_NS:      r_cfg.wall_nanoseconds <= i_cfg.data[WALL_NS_W-1:0];
                default: begin
                    // unused codes are dropped
                end
            endcase
        end
    end

endmodule

>>> rtl/ctod_scale.sv
// five stage pipe: delta, pre-shift, split multiply, product merge, base add
// depends on ctod_pkg
module ctod_scale import ctod_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [COUNT_W-1:0] i_counter_now,
    output t_mono_beat         o_beat,
    input  logic               i_ready
);

    localparam int STAGES = 5;

    logic [STAGES-1:0]      r_v;
    logic [STAGES-1:0]      en;
    logic [COUNT_W-1:0]     r_delta;
    logic [COUNT_W-1:0]     r_shifted;
    logic [2*FRAC_W-1:0]    r_p_lo;
    logic [2*FRAC_W-1:0]    r_p_hi;
    logic [COUNT_W-1:0]     r_scaled;
    logic [COUNT_W-1:0]     r_mono;
    logic [COUNT_W-1:0]     n_shifted;
    logic [2*FRAC_W-1:0]    n_p_lo;
    logic [2*FRAC_W-1:0]    n_p_hi;
    logic [SHIFT_W-1:0]     neg_mag;

    // a stage moves when it is empty or the next one moves
    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // signed pre-shift, magnitude 64 on the right clears everything
    always_comb begin
        neg_mag = 7'd0 - $unsigned(i_cfg.scale_shift);
        if (i_cfg.scale_shift[SHIFT_W-1]) begin
            if (neg_mag[SHIFT_W-1]) begin
                n_shifted = '0;
            end else begin
                n_shifted = r_delta >> neg_mag[5:0];
            end
        end else begin
            n_shifted = r_delta << i_cfg.scale_shift[5:0];
        end
    end

    assign n_p_lo = r_shifted[FRAC_W-1:0] * i_cfg.scale_fraction;
    assign n_p_hi = r_shifted[COUNT_W-1:FRAC_W] * i_cfg.scale_fraction;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~en) | ({r_v[STAGES-2:0], i_valid} & en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_delta <= i_counter_now - i_cfg.counter_base;
        end
        if (en[1]) begin
            r_shifted <= n_shifted;
        end
        if (en[2]) begin
            r_p_lo <= n_p_lo;
            r_p_hi <= n_p_hi;
        end
        if (en[3]) begin
            // bits 32 to 95 of the 96 bit product
            r_scaled <= r_p_hi + {{FRAC_W{1'b0}}, r_p_lo[2*FRAC_W-1:FRAC_W]};
        end
        if (en[4]) begin
            r_mono <= i_cfg.time_base_ns + r_scaled;
        end
    end

    assign o_ready      = en[0];
    assign o_beat.valid = r_v[STAGES-1];
    assign o_beat.mono  = r_mono;

endmodule

>>> rtl/ctod_split.sv
// wall-time pipe: nanosecond sum, reciprocal division by 1e9 with one correction step,
// reciprocal division by 1000 and output register; depends on ctod_pkg
module ctod_split import ctod_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_mono_beat         i_beat,
    output logic               o_ready,
    output logic               o_valid,
    output logic [COUNT_W-1:0] o_monotonic_ns,
    output logic [COUNT_W-1:0] o_seconds,
    output logic [USEC_W-1:0]  o_microseconds,
    input  logic               i_ready
);

    localparam int STAGES     = 7;
    localparam int HALF_W     = COUNT_W / 2;
    localparam int QUOT_W     = 35;
    localparam int RHI_W      = QUOT_W - HALF_W;
    localparam int REM_W      = WALL_NS_W + 1;
    localparam int US_RECIP_W = 31;
    localparam int US_SHIFT   = 40;

    // floor(2^64 / 1e9): the quotient estimate falls short by at most one
    localparam logic [COUNT_W-1:0]   SEC_RECIP = 64'hFFFF_FFFF_FFFF_FFFF / NS_PER_SEC;
    localparam logic [HALF_W-1:0]    RECIP_LO  = SEC_RECIP[HALF_W-1:0];
    localparam logic [RHI_W-1:0]     RECIP_HI  = SEC_RECIP[QUOT_W-1:HALF_W];
    localparam logic [WALL_NS_W-1:0] SEC_DIV   = NS_PER_SEC[WALL_NS_W-1:0];
    // ceil(2^40 / 1000): exact for every remainder below 1e9
    localparam logic [COUNT_W-1:0]    US_RECIP_FULL =
        ((64'd1 << US_SHIFT) - 64'd1) / NS_PER_US + 64'd1;
    localparam logic [US_RECIP_W-1:0] US_RECIP = US_RECIP_FULL[US_RECIP_W-1:0];

    logic [STAGES-1:0]               r_v;
    logic [STAGES-1:0]               en;
    logic [COUNT_W-1:0]              r_sum;
    logic [COUNT_W-1:0]              r_mono0;
    logic [HALF_W-1:0]               r_p0_hi;
    logic [COUNT_W-1:0]              r_p1;
    logic [QUOT_W-1:0]               r_p2;
    logic [QUOT_W-1:0]               r_p3;
    logic [REM_W-1:0]                r_x1;
    logic [COUNT_W-1:0]              r_mono1;
    logic [QUOT_W-1:0]               r_q2;
    logic [REM_W-1:0]                r_x2;
    logic [COUNT_W-1:0]              r_mono2;
    logic [QUOT_W-1:0]               r_q3;
    logic [REM_W-1:0]                r_qd3;
    logic [REM_W-1:0]                r_x3;
    logic [COUNT_W-1:0]              r_mono3;
    logic [QUOT_W-1:0]               r_q4;
    logic [REM_W-1:0]                r_rem4;
    logic [COUNT_W-1:0]              r_mono4;
    logic [COUNT_W-1:0]              r_sec5;
    logic [WALL_NS_W-1:0]            r_rem5;
    logic [COUNT_W-1:0]              r_mono5;
    logic [COUNT_W-1:0]              r_sec6;
    logic [USEC_W-1:0]               r_usec6;
    logic [COUNT_W-1:0]              r_mono6;
    logic [COUNT_W-1:0]              n_p0;
    logic [COUNT_W-1:0]              n_p1;
    logic [QUOT_W-1:0]               n_p2;
    logic [QUOT_W-1:0]               n_p3;
    logic [COUNT_W:0]                n_mid;
    logic [QUOT_W-1:0]               n_q2;
    logic [REM_W-1:0]                n_qd3;
    logic                            n_over;
    logic [WALL_NS_W-1:0]            n_rem5;
    logic [COUNT_W-1:0]              n_sec5;
    logic [WALL_NS_W+US_RECIP_W-1:0] n_us_prod;

    always_comb begin
        en[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= (r_v & ~en) | ({r_v[STAGES-2:0], i_beat.valid} & en);
        end
    end

    // sum times reciprocal as four partial products, top 35 bits kept
    assign n_p0  = r_sum[HALF_W-1:0] * RECIP_LO;
    assign n_p1  = r_sum[COUNT_W-1:HALF_W] * RECIP_LO;
    assign n_p2  = r_sum[HALF_W-1:0] * RECIP_HI;
    assign n_p3  = r_sum[COUNT_W-1:HALF_W] * RECIP_HI;
    assign n_mid = {1'b0, r_p1} + (COUNT_W + 1)'(r_p2) + (COUNT_W + 1)'(r_p0_hi);
    assign n_q2  = r_p3 + QUOT_W'(n_mid[COUNT_W:HALF_W]);

    // remainder is below 2e9, so only its low bits need computing
    assign n_qd3 = r_q2[REM_W-1:0] * SEC_DIV;

    // one correction step brings the remainder below 1e9
    assign n_over = (r_rem4 >= {1'b0, SEC_DIV});
    assign n_rem5 = n_over ? WALL_NS_W'(r_rem4 - {1'b0, SEC_DIV}) : r_rem4[WALL_NS_W-1:0];
    assign n_sec5 = i_cfg.wall_seconds + COUNT_W'(r_q4) + COUNT_W'(n_over);

    assign n_us_prod = r_rem5 * US_RECIP;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_sum   <= i_beat.mono + COUNT_W'(i_cfg.wall_nanoseconds);
            r_mono0 <= i_beat.mono;
        end
        if (en[1]) begin
            r_p0_hi <= n_p0[COUNT_W-1:HALF_W];
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_x1    <= r_sum[REM_W-1:0];
            r_mono1 <= r_mono0;
        end
        if (en[2]) begin
            r_q2    <= n_q2;
            r_x2    <= r_x1;
            r_mono2 <= r_mono1;
        end
        if (en[3]) begin
            r_q3    <= r_q2;
            r_qd3   <= n_qd3;
            r_x3    <= r_x2;
            r_mono3 <= r_mono2;
        end
        if (en[4]) begin
            r_q4    <= r_q3;
            r_rem4  <= r_x3 - r_qd3;
            r_mono4 <= r_mono3;
        end
        if (en[5]) begin
            r_sec5  <= n_sec5;
            r_rem5  <= n_rem5;
            r_mono5 <= r_mono4;
        end
        if (en[6]) begin
            r_sec6  <= r_sec5;
            r_usec6 <= n_us_prod[US_SHIFT+USEC_W-1:US_SHIFT];
            r_mono6 <= r_mono5;
        end
    end

    assign o_ready        = en[0];
    assign o_valid        = r_v[STAGES-1];
    assign o_monotonic_ns = r_mono6;
    assign o_seconds      = r_sec6;
    assign o_microseconds = r_usec6;

endmodule

>>> rtl/counter_to_time_of_day.sv
// counter to time-of-day converter: cycle counter reading in, monotonic ns and
// wall-clock seconds/microseconds out; depends on ctod_pkg, the channel interfaces,
// ctod_cfg_regs, ctod_scale and ctod_split
//
// usage
//   i_cfg  : register writes (index, data), always ready; write only while no
//            beat is in flight, a new value applies to every later input beat
//   i_in   : one counter reading per beat
//   o_out  : one result beat per input beat, in input order
//   latency: 12 register stages, a result beat is offered 11 cycles after the
//            clock edge that took its input beat
//   throughput: one beat per cycle, set by the 12 stage pipe
//            (5 scaling stages, 1 sum stage, 5 stages of reciprocal division
//            by 1e9 with one correction step, 1 stage of reciprocal division by 1000)
//   stall  : every stage holds while it is full and the stage after it holds;
//            empty stages keep filling, so i_in.ready drops only once the
//            whole pipe is full behind a stalled o_out
//   reset  : synchronous, active low; clears all valid bits and all registers
//            (counter base, time base, fraction, shift, wall seconds and ns)
module counter_to_time_of_day import ctod_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctod_cfg_if.sink   i_cfg,
    ctod_in_if.sink    i_in,
    ctod_out_if.source o_out
);

    t_cfg       cfg;
    t_mono_beat mono_beat;
    logic       split_ready;

    // configuration registers
    ctod_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // counter delta, pre-shift, fraction multiply and time base add
    ctod_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_in.valid),
        .o_ready       (i_in.ready),
        .i_counter_now (i_in.counter_now),
        .o_beat        (mono_beat),
        .i_ready       (split_ready)
    );

    // wall nanosecond sum, split into seconds and microseconds
    ctod_split u_split (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_beat         (mono_beat),
        .o_ready        (split_ready),
        .o_valid        (o_out.valid),
        .o_monotonic_ns (o_out.monotonic_ns),
        .o_seconds      (o_out.seconds),
        .o_microseconds (o_out.microseconds),
        .i_ready        (o_out.ready)
    );

`ifndef SYNTHESIS
    // leftover nanoseconds of a result when the wall reference is zero
    logic [COUNT_W-1:0] chk_rem;
    assign chk_rem = o_out.monotonic_ns - o_out.seconds * NS_PER_SEC;

    a_usec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.microseconds < 20'd1000000))
        else $error("microseconds out of range");

    a_zero_fraction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && cfg.scale_fraction == '0) |-> (o_out.monotonic_ns == cfg.time_base_ns))
        else $error("zero fraction must give the time base");

    a_split_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && cfg.wall_seconds == '0 && cfg.wall_nanoseconds == '0)
        |-> (chk_rem < NS_PER_SEC
             && (chk_rem - COUNT_W'(o_out.microseconds) * NS_PER_US) < NS_PER_US))
        else $error("seconds and microseconds do not match monotonic time");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// testbench for counter_to_time_of_day: directed and random counter readings,
// scoreboard prediction of every result beat; depends on ctod_pkg and the channel interfaces
module testbench;
    import ctod_pkg::*;

    // one expected result beat
    typedef struct packed {
        logic [COUNT_W-1:0] mono;
        logic [COUNT_W-1:0] secs;
        logic [USEC_W-1:0]  usec;
    } t_wall_time;

    // scoreboard: own copy of the registers, predicts each reading into a wall time
    class time_of_day_board;
        t_cfg        regs;
        t_wall_time  due_q[$];
        int unsigned errors;

        function new();
            regs   = '0;
            errors = 0;
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_COUNTER_BASE: regs.counter_base     = value;
                CFG_TIME_BASE_NS: regs.time_base_ns     = value;
                CFG_SCALE_FRAC:   regs.scale_fraction   = value[FRAC_W-1:0];
                CFG_SCALE_SHIFT:  regs.scale_shift      = value[SHIFT_W-1:0];
                CFG_WALL_SECONDS: regs.wall_seconds     = value;
                CFG_WALL_NS:      regs.wall_nanoseconds = value[WALL_NS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // accepted input beat: scale the counter delta and split wall time
        function void note_reading(logic [COUNT_W-1:0] counter_now);
            logic [COUNT_W-1:0] delta;
            logic [COUNT_W-1:0] shifted;
            logic [COUNT_W-1:0] sum;
            logic [SHIFT_W-1:0] sh;
            logic [SHIFT_W-1:0] mag;
            logic [127:0]       product;
            t_wall_time         due;
            delta = counter_now - regs.counter_base;
            sh    = regs.scale_shift;
            if (sh[SHIFT_W-1]) begin
                // right shift, magnitude 1..64; 64 clears everything
                mag     = ~sh + 7'd1;
                shifted = (mag >= 7'd64) ? '0 : (delta >> mag);
            end else begin
                shifted = delta << sh[5:0];
            end
            product  = 128'(shifted) * 128'(regs.scale_fraction);
            due.mono = regs.time_base_ns + product[95:32];
            sum      = due.mono + COUNT_W'(regs.wall_nanoseconds);
            due.secs = regs.wall_seconds + sum / NS_PER_SEC;
            due.usec = USEC_W'((sum % NS_PER_SEC) / NS_PER_US);
            due_q.push_back(due);
        endfunction

        function void check_result(logic [COUNT_W-1:0] mono, logic [COUNT_W-1:0] secs,
                                   logic [USEC_W-1:0] usec);
            t_wall_time due;
            if (due_q.size() == 0) begin
                $error("result beat with no reading waiting: mono %h", mono);
                errors++;
                return;
            end
            due = due_q.pop_front();
            if (mono !== due.mono) begin
                $error("monotonic_ns expected %h actual %h", due.mono, mono);
                errors++;
            end
            if (secs !== due.secs) begin
                $error("seconds expected %h actual %h", due.secs, secs);
                errors++;
            end
            if (usec !== due.usec) begin
                $error("microseconds expected %0d actual %0d", due.usec, usec);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctod_cfg_if cfg_ch ();
    ctod_in_if  in_ch ();
    ctod_out_if out_ch ();

    counter_to_time_of_day dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    time_of_day_board board = new();

    // receiver stall pattern, chosen per phase
    int sink_mode  = 0;
    int sink_tick  = 0;
    int stall_left = 0;
    // sender idles in bursts when set
    bit src_gappy  = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: ready changes at the falling edge only
    always @(negedge i_clk) begin
        sink_tick++;
        case (sink_mode)
            0: out_ch.ready = 1'b1;
            1: out_ch.ready = ($urandom_range(0, 3) != 0);
            2: out_ch.ready = ((sink_tick % 7) < 4);
            default: begin
                // mostly ready with occasional long stalls
                if (stall_left > 0) begin
                    stall_left--;
                    out_ch.ready = 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left   = $urandom_range(5, 40);
                    out_ch.ready = 1'b0;
                end else begin
                    out_ch.ready = 1'b1;
                end
            end
        endcase
    end

    // output monitor: every accepted result beat goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.monotonic_ns, out_ch.seconds, out_ch.microseconds);
    end

    // one register write; entered and left at a falling edge
    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        board.set_register(idx, value);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_all(logic [63:0] cbase, logic [63:0] tbase, logic [63:0] frac,
                           logic [63:0] shift, logic [63:0] wsec, logic [63:0] wns);
        write_register(CFG_COUNTER_BASE, cbase);
        write_register(CFG_TIME_BASE_NS, tbase);
        write_register(CFG_SCALE_FRAC, frac);
        write_register(CFG_SCALE_SHIFT, shift);
        write_register(CFG_WALL_SECONDS, wsec);
        write_register(CFG_WALL_NS, wns);
    endtask

    // one counter beat; valid stays high for a following beat
    task automatic send_reading(logic [COUNT_W-1:0] value);
        in_ch.valid       = 1'b1;
        in_ch.counter_now = value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_reading(value);
        @(negedge i_clk);
    endtask

    // wait until every expected beat is back, then let the pipe settle
    task automatic drain_pipe();
        in_ch.valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_wide();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // random register set, extremes included; upper data bits carry garbage
    task automatic randomize_config();
        logic [63:0] frac;
        logic [63:0] shift;
        logic [63:0] wns;
        logic [6:0]  sh;
        case ($urandom_range(0, 4))
            0:       frac = '0;
            1:       frac = '1;
            default: frac = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0:       sh = 7'h40;                              // shift right by 64
            1:       sh = 7'd63;                              // deepest left shift
            6:       sh = 7'($urandom);
            7:       sh = 7'd0;
            default: sh = 7'($urandom_range(0, 64)) - 7'd32;  // usual -32..32
        endcase
        shift      = {$urandom, $urandom};
        shift[6:0] = sh;
        case ($urandom_range(0, 5))
            0:       wns = 64'd0;
            1:       wns = 64'd999_999_999;
            2:       wns = 64'h3fff_ffff;                     // beyond one second
            default: wns = 64'($urandom_range(0, 999_999_999));
        endcase
        if ($urandom_range(0, 1)) wns[63:30] = 34'({$urandom, $urandom});
        set_all(pick_wide(), pick_wide(), frac, shift, pick_wide(), wns);
    endtask

    // random readings: mostly a rising counter stream, some behind base, some noise
    task automatic random_phase(int n_items);
        int          left_in_burst;
        int          gap;
        logic [63:0] tick;
        logic [63:0] value;
        tick          = board.regs.counter_base + 64'($urandom_range(0, 100_000));
        left_in_burst = $urandom_range(1, 24);
        for (int i = 0; i < n_items; i++) begin
            if (src_gappy && left_in_burst == 0) begin
                in_ch.valid       = 1'b0;
                in_ch.counter_now = {$urandom, $urandom};
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 4);
                repeat (gap) @(negedge i_clk);
                left_in_burst = $urandom_range(1, 24);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    tick  = tick + 64'($urandom_range(0, 5000));
                    value = tick;
                end
                6:       value = board.regs.counter_base - 64'($urandom_range(1, 1000));
                default: value = {$urandom, $urandom};
            endcase
            send_reading(value);
            left_in_burst--;
        end
        in_ch.valid = 1'b0;
    endtask

    initial begin
        logic [63:0] base;
        i_rst_n           = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_COUNTER_BASE;
        cfg_ch.data       = '0;
        in_ch.valid       = 1'b0;
        in_ch.counter_now = '0;
        out_ch.ready      = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // registers straight out of reset
        send_reading(64'd0);
        send_reading('1);
        drain_pipe();

        // counter equal to base, behind base, and at both ends
        base = 64'h0123_4567_89ab_cdef;
        set_all(base, 64'd0, 64'hffff_ffff, 64'd0, 64'd0, 64'd0);
        send_reading(base);
        send_reading(base - 64'd1);
        send_reading('1);
        send_reading(64'd0);
        drain_pipe();

        // left shift by 63 loses the high bits
        write_register(CFG_SCALE_SHIFT, 64'd63);
        send_reading(base + 64'd1);
        send_reading(base - 64'd1);
        drain_pipe();

        // right shift by 64 zeroes the delta
        write_register(CFG_SCALE_SHIFT, 64'h40);
        send_reading('1);
        drain_pipe();

        write_register(CFG_SCALE_SHIFT, 64'h7f);
        send_reading(base - 64'd1);
        drain_pipe();

        write_register(CFG_SCALE_SHIFT, 64'h60);
        send_reading(base + 64'h0000_1234_5678_0000);
        drain_pipe();

        write_register(CFG_SCALE_SHIFT, 64'd32);
        send_reading(base + 64'h0000_0001_0000_0001);
        drain_pipe();

        // time base and nanosecond sum wrap at 64 bits, seconds wrap too
        set_all(64'd0, '1, 64'hffff_ffff, 64'd0, '1, 64'h3fff_ffff);
        send_reading('1);
        send_reading(64'd12345);
        drain_pipe();

        // nanosecond part beyond one second carries into seconds
        set_all(64'd0, 64'd0, 64'd0, 64'd0, 64'd42, 64'h3fff_ffff);
        send_reading(64'd0);
        drain_pipe();
        write_register(CFG_TIME_BASE_NS, 64'd999_999_999);
        write_register(CFG_WALL_NS, 64'd999_999_999);
        send_reading(64'd7);
        drain_pipe();

        // random phases, each under its own settings and idle pattern
        for (int phase = 0; phase < 14; phase++) begin
            randomize_config();
            src_gappy = (phase % 3 != 0);
            sink_mode = phase % 4;
            random_phase(125);
            drain_pipe();
        end

        // any stray beat would show up during the settle
        sink_mode = 0;
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // hard stop in case the handshake hangs
    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
